### hw/rtl/rcw_pkg.sv
// Shared types, constants and helpers for the rainbow colour wheel stepper.
// No dependencies; every other file in hw/rtl refers to this package by scope.
`timescale 1ns / 1ps

package rcw_pkg;

  // Field and working widths
  localparam int COLOR_W   = 8;
  localparam int STEP_W    = 7;
  localparam int WORK_W    = 10;  // holds -100..355 after add and fold
  localparam int SPEED_W   = 6;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FILL    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;  // treated as advance

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_DIR    = 2'd1;

  localparam logic [SPEED_W-1:0] SPEED_MAX   = 6'd50;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 6'd8;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_ZERO = 8'd0;

  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic signed [WORK_W-1:0] work_t;

  localparam work_t FULL_LVL = 10'sd255;
  localparam work_t ZERO_LVL = 10'sd0;

  // Per-channel increments
  typedef struct packed {
    step_t red;
    step_t green;
    step_t blue;
  } steps_t;

  // Rule selection handed to the corner unit
  typedef struct packed {
    logic up;      // 1: up rules, 0: down rules
    logic repair;  // fill and restart steps: fix an all-nonzero colour
  } ctrl_t;

  function automatic work_t step_ext(input step_t s);
    return work_t'({{(WORK_W-STEP_W){s[STEP_W-1]}}, s});
  endfunction

  function automatic work_t color_ext(input logic [COLOR_W-1:0] c);
    return work_t'({{(WORK_W-COLOR_W){1'b0}}, c});
  endfunction

  function automatic step_t speed_step(input logic [SPEED_W-1:0] sp);
    return step_t'({{(STEP_W-SPEED_W){1'b0}}, sp});
  endfunction

  // Saturate a working value to the byte range
  function automatic logic [COLOR_W-1:0] sat8(input work_t v);
    if (v < ZERO_LVL) begin
      return COLOR_ZERO;
    end else if (v > FULL_LVL) begin
      return COLOR_FULL;
    end else begin
      return v[COLOR_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/rainbow_color_wheel_stepper_core.sv
// Top level of the rainbow colour wheel stepper: request register, step logic,
// result register, increment state and configuration. Uses rcw_pkg, rcw_derive, rcw_corner.
// A request waits in the request register; its result is captured in the result register.
// Throughput: one request per cycle while results are taken; one add, fold and saturate pass
// between the two registers, which advance whenever the result slot frees.
// Reset (synchronous, rst high): registers empty, speed 8, direction 0, steps (8,0,0), last 0.
`timescale 1ns / 1ps

module rainbow_color_wheel_stepper_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcw_pkg::SPEED_W-1:0]   cfg_data,
  // requests
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [rcw_pkg::REQ_W-1:0]     req_type,
  input  logic [rcw_pkg::COLOR_W-1:0]   seed_red,
  input  logic [rcw_pkg::COLOR_W-1:0]   seed_green,
  input  logic [rcw_pkg::COLOR_W-1:0]   seed_blue,
  // results
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [rcw_pkg::COLOR_W-1:0]   next_red,
  output logic [rcw_pkg::COLOR_W-1:0]   next_green,
  output logic [rcw_pkg::COLOR_W-1:0]   next_blue
);

  // Request register
  logic                        s1_valid;
  logic [rcw_pkg::REQ_W-1:0]   s1_type;
  logic [rcw_pkg::COLOR_W-1:0] s1_red;
  logic [rcw_pkg::COLOR_W-1:0] s1_green;
  logic [rcw_pkg::COLOR_W-1:0] s1_blue;
  logic                        s1_adv;

  // State and configuration
  rcw_pkg::steps_t             steps;
  logic                        last_way;
  logic [rcw_pkg::SPEED_W-1:0] ramp_speed;
  logic                        advance_direction;

  // Step datapath
  logic                        is_restart;
  logic                        is_advance;
  rcw_pkg::steps_t             derived_steps;
  rcw_pkg::steps_t             base_steps;
  rcw_pkg::steps_t             new_steps;
  rcw_pkg::ctrl_t              ctrl;
  logic [rcw_pkg::COLOR_W-1:0] start_red;
  logic [rcw_pkg::COLOR_W-1:0] start_green;
  logic [rcw_pkg::COLOR_W-1:0] start_blue;
  logic [rcw_pkg::COLOR_W-1:0] calc_red;
  logic [rcw_pkg::COLOR_W-1:0] calc_green;
  logic [rcw_pkg::COLOR_W-1:0] calc_blue;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  // Request decode
  always_comb begin
    unique case (s1_type) inside
      rcw_pkg::REQ_RESTART: begin
        is_restart = 1'b1;
        is_advance = 1'b0;
      end
      rcw_pkg::REQ_FILL: begin
        is_restart = 1'b0;
        is_advance = 1'b0;
      end
      rcw_pkg::REQ_ADVANCE, rcw_pkg::REQ_SPARE: begin
        is_restart = 1'b0;
        is_advance = 1'b1;
      end
      default: begin
        is_restart = 1'b0;
        is_advance = 1'b1;
      end
    endcase
  end

  // Starting colour and increments for this step
  always_comb begin
    start_red   = is_restart ? rcw_pkg::COLOR_ZERO : s1_red;
    start_green = is_restart ? rcw_pkg::COLOR_FULL : s1_green;
    start_blue  = is_restart ? rcw_pkg::COLOR_ZERO : s1_blue;
    if (is_restart) begin
      base_steps = '{red: rcw_pkg::speed_step(ramp_speed), green: '0, blue: '0};
    end else if (is_advance && last_way != advance_direction) begin
      base_steps = derived_steps;
    end else begin
      base_steps = steps;
    end
    ctrl.up     = is_advance && advance_direction;
    ctrl.repair = !is_advance;
  end

  rcw_derive u_derive (
    .seed_red   (s1_red),
    .seed_green (s1_green),
    .seed_blue  (s1_blue),
    .speed      (ramp_speed),
    .up         (advance_direction),
    .steps      (derived_steps)
  );

  rcw_corner u_corner (
    .start_red   (start_red),
    .start_green (start_green),
    .start_blue  (start_blue),
    .base_steps  (base_steps),
    .speed       (ramp_speed),
    .ctrl        (ctrl),
    .next_red    (calc_red),
    .next_green  (calc_green),
    .next_blue   (calc_blue),
    .new_steps   (new_steps)
  );

  // Request register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_type  <= req_type;
      s1_red   <= seed_red;
      s1_green <= seed_green;
      s1_blue  <= seed_blue;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      next_red   <= calc_red;
      next_green <= calc_green;
      next_blue  <= calc_blue;
    end
  end

  // Increment state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steps             <= '{red: rcw_pkg::speed_step(rcw_pkg::SPEED_RESET),
                             green: '0, blue: '0};
      last_way          <= 1'b0;
      ramp_speed        <= rcw_pkg::SPEED_RESET;
      advance_direction <= 1'b0;
    end else begin
      if (s1_adv) begin
        steps <= new_steps;
        if (is_restart) begin
          last_way          <= 1'b1;
          advance_direction <= 1'b0;
        end else if (is_advance) begin
          last_way <= advance_direction;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          rcw_pkg::CFG_RAMP_SPEED: begin
            ramp_speed <= (cfg_data > rcw_pkg::SPEED_MAX) ? rcw_pkg::SPEED_MAX : cfg_data;
          end
          rcw_pkg::CFG_ADV_DIR: begin
            advance_direction <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### hw/rtl/rcw_derive.sv
// Re-derives the channel increments from an incoming colour on a direction change.
// Depends on rcw_pkg.
`timescale 1ns / 1ps

module rcw_derive (
  input  logic [rcw_pkg::COLOR_W-1:0] seed_red,
  input  logic [rcw_pkg::COLOR_W-1:0] seed_green,
  input  logic [rcw_pkg::COLOR_W-1:0] seed_blue,
  input  logic [rcw_pkg::SPEED_W-1:0] speed,
  input  logic                        up,
  output rcw_pkg::steps_t             steps
);

  // Pick the first channel that sits between the rails and ramp it
  always_comb begin
    rcw_pkg::step_t s_fwd;
    rcw_pkg::step_t s_rev;
    s_fwd = up ? rcw_pkg::speed_step(speed) : -rcw_pkg::speed_step(speed);
    s_rev = -s_fwd;
    steps = '0;
    if (seed_red != rcw_pkg::COLOR_FULL && seed_red != rcw_pkg::COLOR_ZERO) begin
      steps.red = (seed_green == rcw_pkg::COLOR_ZERO) ? s_rev : s_fwd;
    end else if (seed_green != rcw_pkg::COLOR_FULL && seed_green != rcw_pkg::COLOR_ZERO) begin
      steps.green = (seed_red == rcw_pkg::COLOR_ZERO) ? s_fwd : s_rev;
    end else if (seed_blue != rcw_pkg::COLOR_FULL && seed_blue != rcw_pkg::COLOR_ZERO) begin
      steps.blue = (seed_green == rcw_pkg::COLOR_ZERO) ? s_fwd : s_rev;
    end
  end

endmodule

### hw/rtl/rcw_corner.sv
// Adds the increments, applies the six corner rules, the fill repair and saturation.
// Depends on rcw_pkg.
`timescale 1ns / 1ps

module rcw_corner (
  input  logic [rcw_pkg::COLOR_W-1:0] start_red,
  input  logic [rcw_pkg::COLOR_W-1:0] start_green,
  input  logic [rcw_pkg::COLOR_W-1:0] start_blue,
  input  rcw_pkg::steps_t             base_steps,
  input  logic [rcw_pkg::SPEED_W-1:0] speed,
  input  rcw_pkg::ctrl_t              ctrl,
  output logic [rcw_pkg::COLOR_W-1:0] next_red,
  output logic [rcw_pkg::COLOR_W-1:0] next_green,
  output logic [rcw_pkg::COLOR_W-1:0] next_blue,
  output rcw_pkg::steps_t             new_steps
);

  always_comb begin
    rcw_pkg::work_t r;
    rcw_pkg::work_t g;
    rcw_pkg::work_t b;
    rcw_pkg::step_t sp;
    logic rh, rl, gh, gl, bh, bl;

    sp = rcw_pkg::speed_step(speed);

    // Step every channel
    r = rcw_pkg::color_ext(start_red)   + rcw_pkg::step_ext(base_steps.red);
    g = rcw_pkg::color_ext(start_green) + rcw_pkg::step_ext(base_steps.green);
    b = rcw_pkg::color_ext(start_blue)  + rcw_pkg::step_ext(base_steps.blue);

    rh = (r >= rcw_pkg::FULL_LVL);
    rl = (r <= rcw_pkg::ZERO_LVL);
    gh = (g >= rcw_pkg::FULL_LVL);
    gl = (g <= rcw_pkg::ZERO_LVL);
    bh = (b >= rcw_pkg::FULL_LVL);
    bl = (b <= rcw_pkg::ZERO_LVL);

    new_steps = base_steps;

    // Corner rules: fold overshoot into the neighbour, choose a new ramp
    if (ctrl.up) begin
      if (rh && gl && bl) begin
        b = b - g; g = rcw_pkg::ZERO_LVL;
        new_steps = '{red: '0, green: '0, blue: sp};
      end else if (rh && gh && bl) begin
        g = g - (r - rcw_pkg::FULL_LVL); r = rcw_pkg::FULL_LVL;
        new_steps = '{red: '0, green: -sp, blue: '0};
      end else if (rl && gh && bl) begin
        r = r - b; b = rcw_pkg::ZERO_LVL;
        new_steps = '{red: sp, green: '0, blue: '0};
      end else if (rl && gh && bh) begin
        b = b - (g - rcw_pkg::FULL_LVL); g = rcw_pkg::FULL_LVL;
        new_steps = '{red: '0, green: '0, blue: -sp};
      end else if (rl && gl && bh) begin
        g = g - r; r = rcw_pkg::ZERO_LVL;
        new_steps = '{red: '0, green: sp, blue: '0};
      end else if (rh && gl && bh) begin
        r = r - (b - rcw_pkg::FULL_LVL); b = rcw_pkg::FULL_LVL;
        new_steps = '{red: -sp, green: '0, blue: '0};
      end
    end else begin
      if (rh && gl && bl) begin
        g = g - b; b = rcw_pkg::ZERO_LVL;
        new_steps = '{red: '0, green: sp, blue: '0};
      end else if (rh && gh && bl) begin
        r = r - (g - rcw_pkg::FULL_LVL); g = rcw_pkg::FULL_LVL;
        new_steps = '{red: -sp, green: '0, blue: '0};
      end else if (rl && gh && bl) begin
        b = b - r; r = rcw_pkg::ZERO_LVL;
        new_steps = '{red: '0, green: '0, blue: sp};
      end else if (rl && gh && bh) begin
        g = g - (b - rcw_pkg::FULL_LVL); b = rcw_pkg::FULL_LVL;
        new_steps = '{red: '0, green: -sp, blue: '0};
      end else if (rl && gl && bh) begin
        r = r - g; g = rcw_pkg::ZERO_LVL;
        new_steps = '{red: sp, green: '0, blue: '0};
      end else if (rh && gl && bh) begin
        b = b - (r - rcw_pkg::FULL_LVL); r = rcw_pkg::FULL_LVL;
        new_steps = '{red: '0, green: '0, blue: -sp};
      end
    end

    // Fill repair: a colour with no dark channel goes back to pure green
    if (ctrl.repair && r > rcw_pkg::ZERO_LVL && g > rcw_pkg::ZERO_LVL &&
        b > rcw_pkg::ZERO_LVL) begin
      r = rcw_pkg::ZERO_LVL;
      g = rcw_pkg::FULL_LVL;
      b = rcw_pkg::ZERO_LVL;
      new_steps = '{red: sp, green: '0, blue: '0};
    end

    next_red   = rcw_pkg::sat8(r);
    next_green = rcw_pkg::sat8(g);
    next_blue  = rcw_pkg::sat8(b);
  end

endmodule

### hw/rtl/rcw_checker.sv
// Port-level checks for the rainbow colour wheel stepper, bound to the top level.
// Depends on rcw_pkg and rainbow_color_wheel_stepper_core.
`timescale 1ns / 1ps

module rcw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [rcw_pkg::COLOR_W-1:0] next_red,
  input logic [rcw_pkg::COLOR_W-1:0] next_green,
  input logic [rcw_pkg::COLOR_W-1:0] next_blue
);

  // A stalled result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_red) &&
      $stable(next_green) && $stable(next_blue))
    else $error("stalled result changed or dropped");

  // With the result slot empty a request is always taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty result slot");

  // An accepted request is followed by a valid result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("no result after accepted request");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind rainbow_color_wheel_stepper_core rcw_checker u_rcw_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .next_red   (next_red),
  .next_green (next_green),
  .next_blue  (next_blue)
);
